/* hdl/wrst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wrst_pkg;
   localparam int MaxServersDefault = 128;
   localparam int IdW = 64;
   localparam int WtW = 32;
   localparam int SumW = 39;
   localparam int AttW = 8;
   localparam int CntW = 8;
   localparam int SlotW = 7;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SELECT = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD_WEIGHT = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_EMPTY = 3'd5,
      ST_DRAW_LARGE = 3'd6
   } status_type;

   // command broadcast to every cell in the chain
   typedef struct packed {
      logic                 write_tail;  // append at tail index
      logic                 do_remove;   // move last into found slot, adjust sums
      logic [IdW-1:0]       new_id;
      logic [WtW-1:0]       new_weight;
      logic [SumW-1:0]      new_sum;
      logic [SumW-1:0]      diff;
   } cell_cmd_type;
endpackage
`default_nettype wire

/* hdl/wrst_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module wrst_cell
   import wrst_pkg::*;
#(
   parameter int IdxW = 7
) (
   input  wire logic              clock,
   input  wire logic [IdxW-1:0]   index,
   input  wire logic [IdxW:0]     count,
   input  wire logic [IdxW-1:0]   found_slot,
   input  wire logic [IdxW-1:0]   last_slot,
   input  wire cell_cmd_type      cmd,
   input  wire logic [IdW-1:0]    last_id,
   input  wire logic [WtW-1:0]    last_weight,
   input  wire logic [IdW-1:0]    probe_id,
   input  wire logic [SumW-1:0]   probe_draw,
   output logic                   id_match,
   output logic                   sum_le,
   output logic [IdW-1:0]         id_out,
   output logic [WtW-1:0]         weight_out
);
   logic [IdW-1:0]  id_ff, id_in;
   logic [WtW-1:0]  wt_ff, wt_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic            live;

   assign live       = ({1'b0, index} < count);
   assign id_match   = live && (id_ff == probe_id);
   assign sum_le     = live && (sum_ff <= probe_draw);
   assign id_out     = id_ff;
   assign weight_out = wt_ff;

   always_comb begin
      id_in  = id_ff;
      wt_in  = wt_ff;
      sum_in = sum_ff;
      if (cmd.write_tail && index == count[IdxW-1:0]) begin
         id_in  = cmd.new_id;
         wt_in  = cmd.new_weight;
         sum_in = cmd.new_sum;
      end
      if (cmd.do_remove) begin
         if (index == found_slot) begin
            id_in = last_id;
            wt_in = last_weight;
         end
         if (index >= found_slot && index < last_slot) begin
            sum_in = sum_ff + cmd.diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      wt_ff  <= wt_in;
      sum_ff <= sum_in;
   end
endmodule
`default_nettype wire

/* hdl/weighted_random_server_table_top.sv */
`timescale 1ns / 1ps
// Weighted random server table.
// Input channel: drive req_* with start high while busy is low; the command
// is taken at that edge. mode selects add, remove or select.
// Result channel: rsp_valid is high for exactly one cycle with rsp_status,
// rsp_chosen_id, rsp_chosen_slot, rsp_last_chance, rsp_server_count and
// rsp_total_weight. Receiver cannot stall; the result is lost if not taken.
// Sequence: match, update, respond; rsp_valid is high in respond. busy stays
// high until the result is shown, so no new command is taken while one is in flight.
// The table is a row of cells, one per slot, each comparing its id and
// running sum in parallel; a priority pick over the row finds the slot.
// CSR: register 0 at address 0 is default_weight, read and write over APB,
// pready always high.
// Reset (synchronous, active high) empties the table, clears total and
// default_weight. Slot contents are not cleared; only live slots are used.
`default_nettype none
module weighted_random_server_table_top
   import wrst_pkg::*;
#(
   parameter int MAX_SERVERS = MaxServersDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [IdW-1:0]     req_server_id,
   input  wire logic [WtW-1:0]     req_weight,
   input  wire logic [SumW-1:0]    req_random_draw,
   input  wire logic [AttW-1:0]    req_attempt,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [IdW-1:0]          rsp_chosen_id,
   output logic [SlotW-1:0]        rsp_chosen_slot,
   output logic                    rsp_last_chance,
   output logic [CntW-1:0]         rsp_server_count,
   output logic [SumW-1:0]         rsp_total_weight,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [1:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   localparam int IdxW = $clog2(MAX_SERVERS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_EXEC  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [WtW-1:0]  dflt_ff;
   logic [IdxW:0]   count_ff, count_in;
   logic [SumW-1:0] total_ff, total_in;
   logic [1:0]      mode_ff;
   logic [IdW-1:0]  id_ff;
   logic [WtW-1:0]  wt_ff;
   logic [SumW-1:0] draw_ff;
   logic [AttW-1:0] att_ff;

   logic            hit_ff;
   logic [IdxW-1:0] hit_slot_ff;
   logic [IdxW-1:0] sel_slot_ff;
   logic [WtW-1:0]  found_wt_ff;
   logic [IdW-1:0]  last_id_ff;
   logic [WtW-1:0]  last_wt_ff;

   status_type      st_ff, st_in;
   logic [IdW-1:0]  cid_ff, cid_in;
   logic [IdxW-1:0] cslot_ff, cslot_in;
   logic            lc_ff, lc_in;

   logic [MAX_SERVERS-1:0] match_v, le_v;
   logic [IdW-1:0]  ids [MAX_SERVERS];
   logic [WtW-1:0]  wts [MAX_SERVERS];
   cell_cmd_type    cmd;
   logic [IdxW-1:0] last_slot;

   logic            hit_c;
   logic [IdxW-1:0] hit_c_slot, sel_c_slot;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? dflt_ff : 32'd0;
   assign busy   = (state_ff != S_IDLE);
   assign last_slot = count_ff[IdxW-1:0] - 1'b1;

   genvar g;
   generate
      for (g = 0; g < MAX_SERVERS; g++) begin : g_cell
         wrst_cell #(.IdxW(IdxW)) u_cell (
            .clock      (clock),
            .index      (IdxW'(g)),
            .count      (count_ff),
            .found_slot (hit_slot_ff),
            .last_slot  (last_slot),
            .cmd        (cmd),
            .last_id    (last_id_ff),
            .last_weight(last_wt_ff),
            .probe_id   (id_ff),
            .probe_draw (draw_ff),
            .id_match   (match_v[g]),
            .sum_le     (le_v[g]),
            .id_out     (ids[g]),
            .weight_out (wts[g])
         );
      end
   endgenerate

   // priority pick: first matching id; first slot whose sum exceeds the draw, else last slot
   always_comb begin
      hit_c      = 1'b0;
      hit_c_slot = '0;
      sel_c_slot = last_slot;
      for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
         if (match_v[i]) begin
            hit_c      = 1'b1;
            hit_c_slot = IdxW'(i);
         end
         if (!le_v[i] && ({1'b0, IdxW'(i)} < count_ff) && IdxW'(i) < last_slot) begin
            sel_c_slot = IdxW'(i);
         end
      end
   end

   logic [WtW-1:0]  eff_w;
   logic [SumW:0]   add_sum;
   assign eff_w   = (wt_ff == '0) ? dflt_ff : wt_ff;
   assign add_sum = {1'b0, total_ff} + (SumW+1)'(eff_w);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      st_in    = st_ff;
      cid_in   = cid_ff;
      cslot_in = cslot_ff;
      lc_in    = lc_ff;
      cmd      = '0;
      cmd.new_id     = id_ff;
      cmd.new_weight = eff_w;
      cmd.new_sum    = add_sum[SumW-1:0];
      cmd.diff       = SumW'(last_wt_ff) - SumW'(found_wt_ff);
      case (state_ff)
         S_IDLE: if (start) state_in = S_MATCH;
         S_MATCH: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_RESP;
            st_in    = ST_OK;
            cid_in   = '0;
            cslot_in = '0;
            lc_in    = 1'b0;
            case (mode_type'(mode_ff))
               MODE_ADD: begin
                  if (eff_w == '0) st_in = ST_BAD_WEIGHT;
                  else if (hit_ff) st_in = ST_DUPLICATE;
                  else if (count_ff >= (IdxW+1)'(MAX_SERVERS)) st_in = ST_FULL;
                  else if (add_sum[SumW]) st_in = ST_BAD_WEIGHT;
                  else begin
                     cmd.write_tail = 1'b1;
                     total_in = add_sum[SumW-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  if (!hit_ff) st_in = ST_NOT_FOUND;
                  else begin
                     cmd.do_remove = 1'b1;
                     total_in = total_ff - SumW'(found_wt_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
               MODE_SELECT: begin
                  lc_in = ((AttW+1)'(att_ff) + 1'b1) == (AttW+1)'(count_ff);
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (draw_ff >= total_ff) st_in = ST_DRAW_LARGE;
                  else begin
                     cid_in   = ids[sel_slot_ff];
                     cslot_in = sel_slot_ff;
                  end
               end
               default: ;
            endcase
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         dflt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         if (psel && penable && pwrite && paddr == 2'd0) dflt_ff <= pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         mode_ff <= req_mode;
         id_ff   <= req_server_id;
         wt_ff   <= req_weight;
         draw_ff <= req_random_draw;
         att_ff  <= req_attempt;
      end
      hit_ff      <= hit_c;
      hit_slot_ff <= hit_c_slot;
      sel_slot_ff <= sel_c_slot;
      found_wt_ff <= wts[hit_c_slot];
      last_id_ff  <= ids[last_slot];
      last_wt_ff  <= wts[last_slot];
      st_ff    <= st_in;
      cid_ff   <= cid_in;
      cslot_ff <= cslot_in;
      lc_ff    <= lc_in;
   end

   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_status       = st_ff;
   assign rsp_chosen_id    = cid_ff;
   assign rsp_chosen_slot  = SlotW'(cslot_ff);
   assign rsp_last_chance  = lc_ff;
   assign rsp_server_count = CntW'(count_ff);
   assign rsp_total_weight = total_ff;
endmodule
`default_nettype wire
